[rtl/core/ven_pkg.sv]
// Shared widths and types for the vector error norm block.
package ven_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int DIFF_W    = SAMPLE_W + 1;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam int ABS_W     = 37;
  localparam int SUM_OUT_W = 36;
  localparam int SQ_W      = 61;
  localparam int ROOT_W    = 31;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_status_t;

endpackage

[rtl/core/ven_sqrt.sv]
// Digit-by-digit floor square root, one result bit per cycle.
module ven_sqrt
  import ven_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output sqrt_status_t      status,
  output logic [ROOT_W-1:0] root_out
);

  logic [SQ_W-1:0] rem;
  logic [SQ_W-1:0] root;
  logic [SQ_W-1:0] bit_pos;
  logic [SQ_W:0]   trial;
  logic            take;

  assign trial = {1'b0, root} + {1'b0, bit_pos};
  assign take  = ({1'b0, rem} >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      status.busy <= 1'b0;
      status.done <= 1'b0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        rem         <= radicand;
        root        <= '0;
        bit_pos     <= {1'b1, {(SQ_W-1){1'b0}}};
        status.busy <= 1'b1;
      end else if (status.busy) begin
        if (take) begin
          rem  <= rem - trial[SQ_W-1:0];
          root <= (root >> 1) + bit_pos;
        end else begin
          root <= root >> 1;
        end
        bit_pos <= bit_pos >> 2;
        if (bit_pos[0]) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

  assign root_out = root[ROOT_W-1:0];

endmodule

[rtl/core/vector_error_norms.sv]
// Top level: L1, L2 and infinity norms of the difference of two streamed vectors.
//
// Input channel (sample_valid / sample_stall): one beat carries a reference
// sample, an approximate sample (signed Q12.12) and last_item. A beat is
// taken when sample_valid is high and sample_stall is low.
// Output channel (result_valid / result_stall): one beat per vector, sent
// after the beat marked last_item, with max |d|, sum |d| and floor sqrt of
// sum d*d. The result sits in an output register until taken.
// Each beat passes through difference, multiply and accumulate steps, and
// the block stalls its input meanwhile. After a last beat the shared
// square-root unit runs 31 iterations, one root bit per cycle; the input
// is stalled until the result has been moved into the output register, so
// the next beat is taken in the cycle after that move at the earliest. A
// stall on the output holds the result and delays the next vector's result
// load, and with it the next beat.
// Reset clears the accumulators, the sequencer and result_valid.
module vector_error_norms
  import ven_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_valid,
  output logic                    sample_stall,
  input  logic signed [SAMPLE_W-1:0] reference,
  input  logic signed [SAMPLE_W-1:0] approx,
  input  logic                    last_item,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [SAMPLE_W-1:0]     max_abs_diff,
  output logic [SUM_OUT_W-1:0]    sum_abs_diff,
  output logic [ROOT_W-1:0]       root_sum_sq
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_SQRT,
    ST_EMIT
  } state_t;

  state_t                state;
  logic [SAMPLE_W-1:0]   mag;
  logic                  last_q;
  logic [PROD_W-1:0]     prod;
  logic [ABS_W-1:0]      abs_accum;
  logic [SQ_W-1:0]       square_accum;
  logic [SAMPLE_W-1:0]   peak_diff;
  logic [SAMPLE_W-1:0]   hold_peak;
  logic [SUM_OUT_W-1:0]  hold_abs;

  logic [DIFF_W-1:0]     diff;
  logic [DIFF_W-1:0]     diff_mag;
  logic [SQ_W-1:0]       sq_next;
  logic                  sqrt_start;
  sqrt_status_t          sqrt_stat;
  logic [ROOT_W-1:0]     sqrt_root;
  logic                  out_free;

  assign sample_stall = (state != ST_IDLE);
  assign diff     = {approx[SAMPLE_W-1], approx} - {reference[SAMPLE_W-1], reference};
  assign diff_mag = diff[DIFF_W-1] ? (DIFF_W'(0) - diff) : diff;
  assign sq_next  = square_accum + SQ_W'(prod);
  assign sqrt_start = (state == ST_ADD) && last_q;
  assign out_free = !result_valid || !result_stall;

  ven_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sq_next),
    .status   (sqrt_stat),
    .root_out (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      abs_accum    <= '0;
      square_accum <= '0;
      peak_diff    <= '0;
    end else begin
      if (result_valid && !result_stall && (state != ST_EMIT)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            mag    <= diff_mag[SAMPLE_W-1:0];
            last_q <= last_item;
            state  <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod      <= mag * mag;
          abs_accum <= abs_accum + ABS_W'(mag);
          if (mag > peak_diff) begin
            peak_diff <= mag;
          end
          state <= ST_ADD;
        end
        ST_ADD: begin
          if (last_q) begin
            hold_peak    <= peak_diff;
            hold_abs     <= abs_accum[SUM_OUT_W-1:0];
            abs_accum    <= '0;
            square_accum <= '0;
            peak_diff    <= '0;
            state        <= ST_SQRT;
          end else begin
            square_accum <= sq_next;
            state        <= ST_IDLE;
          end
        end
        ST_SQRT: begin
          if (sqrt_stat.done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            max_abs_diff <= hold_peak;
            sum_abs_diff <= hold_abs;
            root_sum_sq  <= sqrt_root;
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_done_in_sqrt: assert property (@(posedge clk) disable iff (rst)
    sqrt_stat.done |-> state == ST_SQRT)
    else $error("square root finished outside its wait state");

  a_idle_unit_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !sqrt_stat.busy)
    else $error("square root busy while taking samples");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_EMIT)
    else $error("result raised without a finished vector");
`endif

endmodule
